[design/o2bpp_pkg.sv]
// shared types, codes and colour tables for the oriented 2bpp pixel plotter
// no dependencies; imported by every module of the block except o2bpp_checker
`default_nettype none

package o2bpp_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 32768;
   localparam int ADDR_MAX_W = 16;

   // request operations
   localparam logic [1:0] OP_PLOT = 2'd0;
   localparam logic [1:0] OP_FILL = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_ORIENTATION = 2'd0;
   localparam logic [1:0] CSR_SIZE_V      = 2'd1;
   localparam logic [1:0] CSR_SIZE_H      = 2'd2;
   localparam logic [1:0] CSR_INVERT      = 2'd3;

   localparam logic [1:0] ORIENT_0   = 2'd0;
   localparam logic [1:0] ORIENT_90  = 2'd1;
   localparam logic [1:0] ORIENT_180 = 2'd2;
   localparam logic [1:0] ORIENT_270 = 2'd3;

   localparam logic [9:0] SIZE_V_RESET = 10'd300;
   localparam logic [9:0] SIZE_H_RESET = 10'd400;

   // logical colours
   localparam logic [3:0] COL_BLACK  = 4'd0;
   localparam logic [3:0] COL_WHITE  = 4'd1;
   localparam logic [3:0] COL_RED    = 4'd2;
   localparam logic [3:0] COL_YELLOW = 4'd3;
   localparam logic [3:0] COL_GREY   = 4'd4;
   localparam logic [3:0] COL_DRED   = 4'd5;
   localparam logic [3:0] COL_LRED   = 4'd6;
   localparam logic [3:0] COL_DYEL   = 4'd7;
   localparam logic [3:0] COL_LYEL   = 4'd8;
   localparam logic [3:0] COL_ORANGE = 4'd9;

   // stored pixel codes
   localparam logic [1:0] CODE_BLACK  = 2'b00;
   localparam logic [1:0] CODE_WHITE  = 2'b01;
   localparam logic [1:0] CODE_YELLOW = 2'b10;
   localparam logic [1:0] CODE_RED    = 2'b11;

   // fill patterns
   localparam logic [7:0] PAT_WHITE     = 8'b01010101;
   localparam logic [7:0] PAT_BLACK     = 8'b00000000;
   localparam logic [7:0] PAT_RED       = 8'b11111111;
   localparam logic [7:0] PAT_YELLOW    = 8'b10101010;
   localparam logic [7:0] PAT_GREY_EVN  = 8'b00010001;
   localparam logic [7:0] PAT_GREY_ODD  = 8'b01000100;
   localparam logic [7:0] PAT_DRED_EVN  = 8'b01110111;
   localparam logic [7:0] PAT_DRED_ODD  = 8'b11011101;
   localparam logic [7:0] PAT_LRED_EVN  = 8'b00110011;
   localparam logic [7:0] PAT_LRED_ODD  = 8'b11001100;
   localparam logic [7:0] PAT_DYEL_EVN  = 8'b01100110;
   localparam logic [7:0] PAT_DYEL_ODD  = 8'b10011001;
   localparam logic [7:0] PAT_LYEL_EVN  = 8'b00100010;
   localparam logic [7:0] PAT_LYEL_ODD  = 8'b10001000;
   localparam logic [7:0] PAT_ORNG_EVN  = 8'b11101110;
   localparam logic [7:0] PAT_ORNG_ODD  = 8'b10111011;

   // command kinds handed from front to back
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_PLOT   = 2'd1;
   localparam logic [1:0] KIND_FILL   = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   typedef struct packed {
      logic [1:0] orientation;
      logic [9:0] size_v;
      logic [9:0] size_h;
      logic       invert;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic                  status;
      logic [ADDR_MAX_W-1:0] addr;
      logic [1:0]            lane;
      logic [1:0]            code;
      logic [7:0]            even_pat;
      logic [7:0]            odd_pat;
   } cmd_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] code;
   } pix_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] even_pat;
      logic [7:0] odd_pat;
   } fill_type;

   function automatic pix_type resolve_pixel(input logic [3:0] colour, input logic odd,
                                              input logic inv);
      logic [3:0] basic;
      pix_type    p;
      case (colour)
         COL_GREY:   basic = odd ? COL_WHITE : COL_BLACK;
         COL_DRED:   basic = odd ? (inv ? COL_WHITE : COL_BLACK) : COL_RED;
         COL_LRED:   basic = odd ? (inv ? COL_BLACK : COL_WHITE) : COL_RED;
         COL_DYEL:   basic = odd ? COL_BLACK : COL_YELLOW;
         COL_LYEL:   basic = odd ? COL_WHITE : COL_YELLOW;
         COL_ORANGE: basic = odd ? COL_RED : COL_YELLOW;
         default:    basic = colour;
      endcase
      p.valid = (basic <= COL_YELLOW);
      case (basic)
         COL_BLACK:  p.code = inv ? CODE_WHITE : CODE_BLACK;
         COL_WHITE:  p.code = inv ? CODE_BLACK : CODE_WHITE;
         COL_YELLOW: p.code = CODE_YELLOW;
         default:    p.code = CODE_RED;
      endcase
      return p;
   endfunction

   function automatic fill_type fill_patterns(input logic [3:0] colour, input logic inv);
      fill_type f;
      f.valid = 1'b1;
      f.even_pat = PAT_BLACK;
      f.odd_pat = PAT_BLACK;
      case (colour)
         COL_GREY: begin
            f.even_pat = PAT_GREY_EVN;
            f.odd_pat = PAT_GREY_ODD;
         end
         COL_WHITE: begin
            f.even_pat = inv ? PAT_BLACK : PAT_WHITE;
            f.odd_pat = inv ? PAT_BLACK : PAT_WHITE;
         end
         COL_BLACK: begin
            f.even_pat = inv ? PAT_WHITE : PAT_BLACK;
            f.odd_pat = inv ? PAT_WHITE : PAT_BLACK;
         end
         COL_RED: begin
            f.even_pat = PAT_RED;
            f.odd_pat = PAT_RED;
         end
         COL_DRED: begin
            f.even_pat = PAT_DRED_EVN;
            f.odd_pat = PAT_DRED_ODD;
         end
         COL_LRED: begin
            f.even_pat = PAT_LRED_EVN;
            f.odd_pat = PAT_LRED_ODD;
         end
         COL_YELLOW: begin
            f.even_pat = PAT_YELLOW;
            f.odd_pat = PAT_YELLOW;
         end
         COL_DYEL: begin
            f.even_pat = PAT_DYEL_EVN;
            f.odd_pat = PAT_DYEL_ODD;
         end
         COL_LYEL: begin
            f.even_pat = PAT_LYEL_EVN;
            f.odd_pat = PAT_LYEL_ODD;
         end
         COL_ORANGE: begin
            f.even_pat = PAT_ORNG_EVN;
            f.odd_pat = PAT_ORNG_ODD;
         end
         default: f.valid = 1'b0;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

[design/o2bpp_front.sv]
// front end: input register, rotation, bounds check and colour resolve
// depends on o2bpp_pkg; feeds classified commands to o2bpp_queue
`default_nettype none

module o2bpp_front #(
   parameter int BUFFER_BYTES = o2bpp_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  o2bpp_pkg::cfg_type     cfg,
   input  wire                    clear_busy,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  wire  [1:0]             req_op,
   input  wire  [8:0]             req_x,
   input  wire  [8:0]             req_y,
   input  wire  [3:0]             req_colour,
   input  wire  [14:0]            req_index,
   output logic                   push_valid,
   input  wire                    push_ready,
   output o2bpp_pkg::cmd_type     push_cmd
);
   import o2bpp_pkg::*;

   logic        valid_ff, valid_in;
   logic [1:0]  op_ff;
   logic [8:0]  x_ff;
   logic [8:0]  y_ff;
   logic [3:0]  colour_ff;
   logic [14:0] index_ff;

   logic        accept;
   logic [9:0]  x_ext, y_ext, v, h, row, col;
   logic [7:0]  bpr;
   logic        in_screen, addr_ok, index_ok;
   logic [17:0] prod, byte_addr;
   pix_type     pix;
   fill_type    fill;

   assign accept = req_tvalid && req_tready;
   assign req_tready = !clear_busy && (!valid_ff || push_ready);
   assign push_valid = valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push_valid && push_ready) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         op_ff <= req_op;
         x_ff <= req_x;
         y_ff <= req_y;
         colour_ff <= req_colour;
         index_ff <= req_index;
      end
   end

   // rotation and screen check
   always_comb begin
      x_ext = {1'b0, x_ff};
      y_ext = {1'b0, y_ff};
      v = cfg.size_v;
      h = cfg.size_h;
      case (cfg.orientation)
         ORIENT_0: begin
            in_screen = (x_ext < h) && (y_ext < v);
            row = y_ext;
            col = x_ext;
         end
         ORIENT_90: begin
            in_screen = (x_ext < v) && (y_ext < h);
            row = x_ext;
            col = h - 10'd1 - y_ext;
         end
         ORIENT_180: begin
            in_screen = (x_ext < h) && (y_ext < v);
            row = v - 10'd1 - y_ext;
            col = h - 10'd1 - x_ext;
         end
         default: begin
            in_screen = (x_ext < v) && (y_ext < h);
            row = v - 10'd1 - x_ext;
            col = y_ext;
         end
      endcase
   end

   assign bpr = cfg.size_h[9:2];
   assign prod = {8'd0, row} * {10'd0, bpr};
   assign byte_addr = prod + {10'd0, col[9:2]};
   assign addr_ok = byte_addr < 18'(BUFFER_BYTES);
   assign index_ok = {2'b00, index_ff} < 17'(BUFFER_BYTES);
   assign pix = resolve_pixel(colour_ff, row[0] ^ col[0], cfg.invert);
   assign fill = fill_patterns(colour_ff, cfg.invert);

   always_comb begin
      push_cmd.kind = KIND_STATUS;
      push_cmd.status = 1'b0;
      push_cmd.addr = byte_addr[ADDR_MAX_W-1:0];
      push_cmd.lane = col[1:0];
      push_cmd.code = pix.code;
      push_cmd.even_pat = fill.even_pat;
      push_cmd.odd_pat = fill.odd_pat;
      case (op_ff)
         OP_PLOT: begin
            if (!in_screen || !addr_ok) begin
               push_cmd.status = 1'b1;
            end else if (pix.valid) begin
               push_cmd.kind = KIND_PLOT;
            end
         end
         OP_FILL: begin
            if (fill.valid) begin
               push_cmd.kind = KIND_FILL;
            end
         end
         OP_READ: begin
            push_cmd.addr = ADDR_MAX_W'(index_ff);
            if (index_ok) begin
               push_cmd.kind = KIND_READ;
            end else begin
               push_cmd.status = 1'b1;
            end
         end
         default: push_cmd.status = 1'b1;
      endcase
   end

endmodule

`default_nettype wire

[design/o2bpp_queue.sv]
// two-entry command queue between front and back
// depends on o2bpp_pkg for the command type
`default_nettype none

module o2bpp_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  o2bpp_pkg::cmd_type  push_cmd,
   output logic                pop_valid,
   input  wire                 pop_req,
   output o2bpp_pkg::cmd_type  pop_cmd
);
   import o2bpp_pkg::*;

   localparam int Depth = 2;
   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   cmd_type             entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != CntW'(Depth);
   assign pop_valid = count_ff != '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_req && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[design/o2bpp_back.sv]
// back end: frame store, clearing pass, plot read-modify-write, fill sweep, read
// depends on o2bpp_pkg; takes commands from o2bpp_queue, drives the result channel
`default_nettype none

module o2bpp_back #(
   parameter int BUFFER_BYTES = o2bpp_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  o2bpp_pkg::cfg_type  cfg,
   output logic                clear_busy,
   input  wire                 pop_valid,
   output logic                pop_req,
   input  o2bpp_pkg::cmd_type  pop_cmd,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [7:0]          rsp_data,
   output logic                rsp_status
);
   import o2bpp_pkg::*;

   localparam int AddrW = $clog2(BUFFER_BYTES);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_ACCESS = 3'd2;
   localparam logic [2:0] ST_FILL   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [7:0]       store_ff [BUFFER_BYTES];
   logic [7:0]       rd_data_ff;

   logic [2:0]       state_ff, state_in;
   cmd_type          cur_ff, cur_in;
   logic [AddrW:0]   ptr_ff, ptr_in;
   logic [7:0]       col_ff, col_in;
   logic [9:0]       row_ff, row_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;

   logic             mem_we, mem_re;
   logic [AddrW-1:0] mem_wa, mem_ra;
   logic [7:0]       mem_wd, merged;
   logic [7:0]       bpr;
   logic             slot_free, deliver;

   assign bpr = cfg.size_h[9:2];
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign mem_ra = pop_cmd.addr[AddrW-1:0];
   assign clear_busy = state_ff == ST_CLEAR;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign rsp_status = rsp_status_ff;

   // msb pair is the leftmost pixel
   always_comb begin
      merged = rd_data_ff;
      case (cur_ff.lane)
         2'd0:    merged[7:6] = cur_ff.code;
         2'd1:    merged[5:4] = cur_ff.code;
         2'd2:    merged[3:2] = cur_ff.code;
         default: merged[1:0] = cur_ff.code;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      ptr_in = ptr_ff;
      col_in = col_ff;
      row_in = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = ptr_ff[AddrW-1:0];
      mem_wd = 8'd0;
      pop_req = 1'b0;
      deliver = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (ptr_ff == (AddrW + 1)'(BUFFER_BYTES - 1)) begin
               ptr_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop_valid) begin
               pop_req = 1'b1;
               cur_in = pop_cmd;
               case (pop_cmd.kind)
                  KIND_PLOT, KIND_READ: begin
                     mem_re = 1'b1;
                     state_in = ST_ACCESS;
                  end
                  KIND_FILL: begin
                     ptr_in = '0;
                     col_in = '0;
                     row_in = '0;
                     state_in = (cfg.size_v == 10'd0 || bpr == 8'd0) ? ST_DONE : ST_FILL;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_ACCESS: begin
            if (cur_ff.kind == KIND_PLOT) begin
               mem_we = 1'b1;
               mem_wa = cur_ff.addr[AddrW-1:0];
               mem_wd = merged;
            end
            deliver = slot_free;
            state_in = slot_free ? ST_IDLE : ST_DONE;
         end
         ST_FILL: begin
            if (ptr_ff >= (AddrW + 1)'(BUFFER_BYTES)) begin
               state_in = ST_DONE;
            end else begin
               mem_we = 1'b1;
               mem_wd = row_ff[0] ? cur_ff.odd_pat : cur_ff.even_pat;
               ptr_in = ptr_ff + 1'b1;
               if (col_ff == bpr - 8'd1) begin
                  col_in = '0;
                  if (row_ff == cfg.size_v - 10'd1) begin
                     state_in = ST_DONE;
                  end else begin
                     row_in = row_ff + 10'd1;
                  end
               end else begin
                  col_in = col_ff + 8'd1;
               end
            end
         end
         ST_DONE: begin
            deliver = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (deliver) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = cur_ff.status;
         rsp_data_in = (cur_ff.kind == KIND_READ) ? rd_data_ff : 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ptr_ff <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      col_ff <= col_in;
      row_ff <= row_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= store_ff[mem_ra];
      end
   end

endmodule

`default_nettype wire

[design/oriented_2bpp_pixel_plotter_unit.sv]
// a plot or read passes the input register, the queue and the back end's access state
// back end: takes one item at a time; a fill writes size_v rows of size_h / 4 bytes,
//   cut at the store end
// reset: registers return to defaults, then a clearing pass writes zero to every byte
//   of the frame store; req_tready stays low until it ends
// top level: configuration registers, front, queue and back; depends on o2bpp_pkg
`default_nettype none

module oriented_2bpp_pixel_plotter_unit #(
   parameter int BUFFER_BYTES = o2bpp_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [39:0] req_tdata,  // x_coord, y_coord, colour_code, read_index, zero pad
   input  wire  [1:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,  // read_data
   output logic        rsp_tuser,  // status
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_addr,
   input  wire  [9:0]  csr_wdata
);
   import o2bpp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    clear_busy;
   logic    push_valid, push_ready, pop_valid, pop_req;
   cmd_type push_cmd, pop_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_addr)
            CSR_ORIENTATION: cfg_in.orientation = csr_wdata[1:0];
            CSR_SIZE_V:      cfg_in.size_v = csr_wdata;
            CSR_SIZE_H:      cfg_in.size_h = csr_wdata;
            CSR_INVERT:      cfg_in.invert = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.orientation <= ORIENT_0;
         cfg_ff.size_v <= SIZE_V_RESET;
         cfg_ff.size_h <= SIZE_H_RESET;
         cfg_ff.invert <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   o2bpp_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clear_busy (clear_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .req_x      (req_tdata[8:0]),
      .req_y      (req_tdata[17:9]),
      .req_colour (req_tdata[21:18]),
      .req_index  (req_tdata[36:22]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   o2bpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_req    (pop_req),
      .pop_cmd    (pop_cmd)
   );

   o2bpp_back #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clear_busy (clear_busy),
      .pop_valid  (pop_valid),
      .pop_req    (pop_req),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

endmodule

`default_nettype wire

[design/o2bpp_checker.sv]
// port-level checks on the pixel plotter, bound to the top level
// no package dependency; watches only the top level's ports
`default_nettype none

module o2bpp_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_tvalid,
   input wire       req_tready,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tuser
);

   logic [3:0] pending_ff, pending_in;

   // items taken whose result is not yet out
   always_comb begin
      pending_in = pending_ff;
      if ((req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         pending_in = pending_ff + 4'd1;
      end else if (!(req_tvalid && req_tready) && (rsp_tvalid && rsp_tready)) begin
         pending_in = pending_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_no_rsp : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_reset_clearing : assert property (@(posedge clock) reset |=> !req_tready)
      else $error("input ready during clearing pass");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_ignored_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 8'd0)
      else $error("ignored item returned data");

   a_no_orphan : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != 4'd0)
      else $error("result without a pending item");

endmodule

bind oriented_2bpp_pixel_plotter_unit o2bpp_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[bench/tb.sv]
// self-checking bench for oriented_2bpp_pixel_plotter_unit: directed table, then random phases
// under several register settings; results are checked against table values or an in-bench frame store model
// depends on o2bpp_pkg and the rtl of the block
`default_nettype none

module tb;
   import o2bpp_pkg::*;

   localparam int BUF_BYTES = BUFFER_BYTES_DEFAULT;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [3:0] COL_NONE = 4'd12;
   localparam logic [3:0] COL_NONE_MAX = 4'd15;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 16;

   typedef struct packed {
      logic       status;
      logic [7:0] data;
   } plot_result_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [8:0]  x;
      logic [8:0]  y;
      logic [3:0]  colour;
      logic [14:0] idx;
      logic        typed;
      logic        status;
      logic [7:0]  data;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_addr = '0;
   logic [9:0]  csr_wdata = '0;

   // frame store model and its registers
   logic [7:0]  frame_img [0:BUF_BYTES-1];
   logic [1:0]  m_orient;
   int unsigned m_v;
   int unsigned m_h;
   logic        m_inv;
   int unsigned recent_addr;

   plot_result_type owed_results [$];
   plot_result_type head;
   int          errors = 0;
   logic        idle_on = 1'b1;
   logic        hold_req = 1'b0;
   logic        hold_seen;
   int          hold_left;
   int          burst_left;
   table_row_type dir_rows [26];

   oriented_2bpp_pixel_plotter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #16_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [1:0] pixel_code(input logic [3:0] basic);
      if (basic == COL_BLACK) return m_inv ? CODE_WHITE : CODE_BLACK;
      if (basic == COL_WHITE) return m_inv ? CODE_BLACK : CODE_WHITE;
      if (basic == COL_YELLOW) return CODE_YELLOW;
      return CODE_RED;
   endfunction

   task automatic frame_op(input logic [1:0] op, input logic [8:0] x, input logic [8:0] y,
                           input logic [3:0] colour, input logic [14:0] idx,
                           output plot_result_type res);
      int unsigned xi, yi, row, col, z, bpr, span;
      logic        ok, odd, paint;
      logic [3:0]  basic;
      logic [7:0]  pat_even, pat_odd;
      int          sh;
      res = '0;
      xi = x;
      yi = y;
      row = 0;
      col = 0;
      ok = 1'b0;
      case (op)
         OP_PLOT: begin
            case (m_orient)
               ORIENT_0: if (xi < m_h && yi < m_v) begin
                  row = yi; col = xi; ok = 1'b1;
               end
               ORIENT_90: if (xi < m_v && yi < m_h) begin
                  row = xi; col = m_h - 1 - yi; ok = 1'b1;
               end
               ORIENT_180: if (xi < m_h && yi < m_v) begin
                  row = m_v - 1 - yi; col = m_h - 1 - xi; ok = 1'b1;
               end
               default: if (xi < m_v && yi < m_h) begin
                  row = m_v - 1 - xi; col = yi; ok = 1'b1;
               end
            endcase
            z = row * (m_h >> 2) + (col >> 2);
            if (!ok || z >= BUF_BYTES) begin
               res.status = 1'b1;
            end else begin
               odd = row[0] ^ col[0];
               basic = colour;
               case (colour)
                  COL_GREY:   basic = odd ? COL_WHITE : COL_BLACK;
                  COL_DRED:   basic = !odd ? COL_RED : (m_inv ? COL_WHITE : COL_BLACK);
                  COL_LRED:   basic = !odd ? COL_RED : (m_inv ? COL_BLACK : COL_WHITE);
                  COL_DYEL:   basic = odd ? COL_BLACK : COL_YELLOW;
                  COL_LYEL:   basic = odd ? COL_WHITE : COL_YELLOW;
                  COL_ORANGE: basic = odd ? COL_RED : COL_YELLOW;
                  default:    basic = colour;
               endcase
               if (basic <= COL_YELLOW) begin
                  sh = 6 - 2 * (col % 4);
                  frame_img[z][sh +: 2] = pixel_code(basic);
                  recent_addr = z;
               end
            end
         end
         OP_FILL: begin
            paint = 1'b1;
            pat_even = PAT_BLACK;
            pat_odd = PAT_BLACK;
            case (colour)
               COL_BLACK: begin
                  pat_even = m_inv ? 8'h55 : 8'h00; pat_odd = pat_even;
               end
               COL_WHITE: begin
                  pat_even = m_inv ? 8'h00 : 8'h55; pat_odd = pat_even;
               end
               COL_RED: begin
                  pat_even = 8'hFF; pat_odd = 8'hFF;
               end
               COL_YELLOW: begin
                  pat_even = 8'hAA; pat_odd = 8'hAA;
               end
               COL_GREY: begin
                  pat_even = 8'h11; pat_odd = 8'h44;
               end
               COL_DRED: begin
                  pat_even = 8'h77; pat_odd = 8'hDD;
               end
               COL_LRED: begin
                  pat_even = 8'h33; pat_odd = 8'hCC;
               end
               COL_DYEL: begin
                  pat_even = 8'h66; pat_odd = 8'h99;
               end
               COL_LYEL: begin
                  pat_even = 8'h22; pat_odd = 8'h88;
               end
               COL_ORANGE: begin
                  pat_even = 8'hEE; pat_odd = 8'hBB;
               end
               default: paint = 1'b0;
            endcase
            bpr = m_h >> 2;
            span = m_v * bpr;
            if (span > BUF_BYTES) span = BUF_BYTES;
            if (paint) begin
               for (int unsigned a = 0; a < span; a++)
                  frame_img[a] = ((a / bpr) % 2) ? pat_odd : pat_even;
            end
         end
         OP_READ: begin
            if (idx < BUF_BYTES) res.data = frame_img[idx];
            else res.status = 1'b1;
         end
         default: res.status = 1'b1;
      endcase
   endtask

   task automatic send_item(input logic [1:0] op, input logic [8:0] x, input logic [8:0] y,
                            input logic [3:0] colour, input logic [14:0] idx,
                            input logic typed, input logic t_status, input logic [7:0] t_data);
      plot_result_type res;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {3'b000, idx, colour, y, x};
      do @(posedge clock); while (!req_tready);
      frame_op(op, x, y, colour, idx, res);
      if (typed) begin
         res.status = t_status;
         res.data = t_data;
      end
      owed_results.push_back(res);
   endtask

   task automatic send_random(input int unsigned fill_pct);
      int unsigned pick, xlim, ylim, span;
      logic [1:0]  op;
      logic [8:0]  x, y;
      logic [3:0]  colour;
      logic [14:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < fill_pct) op = OP_FILL;
      else if (pick < 60) op = OP_PLOT;
      else if (pick < 96) op = OP_READ;
      else op = OP_UNUSED;
      colour = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                           : 4'($urandom_range(0, 9));
      xlim = m_orient[0] ? m_v : m_h;
      ylim = m_orient[0] ? m_h : m_v;
      if (op == OP_PLOT && $urandom_range(0, 99) < 85) begin
         x = 9'($urandom_range(0, xlim - 1));
         y = 9'($urandom_range(0, ylim - 1));
      end else begin
         x = 9'($urandom);
         y = 9'($urandom);
      end
      span = m_v * (m_h >> 2);
      if (span > BUF_BYTES) span = BUF_BYTES;
      pick = $urandom_range(0, 9);
      if (op == OP_READ && pick < 3) idx = 15'(recent_addr);
      else if (op == OP_READ && pick < 8) idx = 15'($urandom_range(0, span - 1));
      else idx = 15'($urandom);
      send_item(op, x, y, colour, idx, 1'b0, 1'b0, 8'h00);
   endtask

   task automatic wait_drained;
      req_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_xfer(input logic [1:0] a, input logic [9:0] d);
      csr_valid <= 1'b1;
      csr_addr <= a;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(input logic [1:0] orient, input logic [9:0] v, input logic [9:0] h,
                             input logic inv);
      csr_xfer(CSR_ORIENTATION, {8'd0, orient});
      csr_xfer(CSR_SIZE_V, v);
      csr_xfer(CSR_SIZE_H, h);
      csr_xfer(CSR_INVERT, {9'd0, inv});
      csr_valid <= 1'b0;
      m_orient = orient;
      m_v = v;
      m_h = h;
      m_inv = inv;
   endtask

   task automatic run_phase(input logic [1:0] orient, input logic [9:0] v, input logic [9:0] h,
                            input logic inv, input int n, input int unsigned fill_pct,
                            input logic big_fill, input logic long_hold);
      set_config(orient, v, h, inv);
      if (big_fill) send_item(OP_FILL, 9'd0, 9'd0, COL_ORANGE, 15'd0, 1'b0, 1'b0, 8'h00);
      if (long_hold) hold_req <= ~hold_req;
      for (int i = 0; i < n; i++) send_random(fill_pct);
      wait_drained();
   endtask

   // receiver side: long hold on request, otherwise short random stall bursts while idle_on is set
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_seen <= hold_req;
         hold_left <= 0;
         burst_left <= 0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (burst_left != 0) begin
         burst_left <= burst_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         burst_left <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_results.size() == 0) begin
            $display("%0t: transfer with nothing expected: status %0d data %02h",
                     $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            head = owed_results.pop_front();
            if (rsp_tuser !== head.status) begin
               $display("%0t: status expected %0d actual %0d", $time, head.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata !== head.data) begin
               $display("%0t: read_data expected %02h actual %02h", $time, head.data, rsp_tdata);
               errors++;
            end
         end
      end
   end

   initial begin
      for (int a = 0; a < BUF_BYTES; a++) frame_img[a] = 8'h00;
      m_orient = ORIENT_0;
      m_v = SIZE_V_RESET;
      m_h = SIZE_H_RESET;
      m_inv = 1'b0;
      recent_addr = 0;
      dir_rows = '{
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd0,     1'b1, 1'b0, 8'h00},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd32767, 1'b1, 1'b0, 8'h00},
         '{OP_UNUSED, 9'd511, 9'd511, COL_NONE_MAX, 15'd32767, 1'b1, 1'b1, 8'h00},
         '{OP_PLOT,   9'd0,   9'd0,   COL_WHITE,    15'd0,     1'b1, 1'b0, 8'h00},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd0,     1'b1, 1'b0, 8'h40},
         '{OP_PLOT,   9'd399, 9'd299, COL_RED,      15'd0,     1'b1, 1'b0, 8'h00},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd29999, 1'b1, 1'b0, 8'h03},
         '{OP_PLOT,   9'd400, 9'd0,   COL_WHITE,    15'd0,     1'b1, 1'b1, 8'h00},
         '{OP_PLOT,   9'd511, 9'd511, COL_NONE_MAX, 15'd0,     1'b1, 1'b1, 8'h00},
         '{OP_PLOT,   9'd0,   9'd300, COL_BLACK,    15'd0,     1'b1, 1'b1, 8'h00},
         '{OP_PLOT,   9'd1,   9'd0,   COL_NONE,     15'd0,     1'b1, 1'b0, 8'h00},
         '{OP_PLOT,   9'd2,   9'd0,   COL_GREY,     15'd0,     1'b0, 1'b0, 8'h00},
         '{OP_PLOT,   9'd3,   9'd0,   COL_DRED,     15'd0,     1'b0, 1'b0, 8'h00},
         '{OP_PLOT,   9'd5,   9'd0,   COL_LRED,     15'd0,     1'b0, 1'b0, 8'h00},
         '{OP_PLOT,   9'd6,   9'd0,   COL_DYEL,     15'd0,     1'b0, 1'b0, 8'h00},
         '{OP_PLOT,   9'd7,   9'd0,   COL_LYEL,     15'd0,     1'b0, 1'b0, 8'h00},
         '{OP_PLOT,   9'd9,   9'd0,   COL_ORANGE,   15'd0,     1'b0, 1'b0, 8'h00},
         '{OP_PLOT,   9'd10,  9'd0,   COL_YELLOW,   15'd0,     1'b0, 1'b0, 8'h00},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd0,     1'b0, 1'b0, 8'h00},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd1,     1'b0, 1'b0, 8'h00},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd2,     1'b0, 1'b0, 8'h00},
         '{OP_FILL,   9'd0,   9'd0,   COL_NONE,     15'd0,     1'b1, 1'b0, 8'h00},
         '{OP_FILL,   9'd0,   9'd0,   COL_GREY,     15'd0,     1'b1, 1'b0, 8'h00},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd0,     1'b1, 1'b0, 8'h11},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd100,   1'b1, 1'b0, 8'h44},
         '{OP_READ,   9'd0,   9'd0,   COL_BLACK,    15'd30000, 1'b1, 1'b0, 8'h00}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i])
         send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].colour,
                   dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].status, dir_rows[i].data);
      wait_drained();

      run_phase(ORIENT_0,   10'd4,   10'd4,   1'b0, 120, 6, 1'b0, 1'b0);
      run_phase(ORIENT_90,  10'd8,   10'd12,  1'b1, 120, 6, 1'b0, 1'b0);
      run_phase(ORIENT_180, 10'd16,  10'd20,  1'b0, 120, 6, 1'b0, 1'b1);
      run_phase(ORIENT_270, 10'd10,  10'd6,   1'b1, 120, 6, 1'b0, 1'b0);
      run_phase(ORIENT_90,  10'd512, 10'd512, 1'b0, 120, 0, 1'b1, 1'b0);
      run_phase(ORIENT_180, 10'd300, 10'd400, 1'b1, 120, 0, 1'b0, 1'b0);
      run_phase(ORIENT_270, 10'd64,  10'd64,  1'b0, 120, 6, 1'b0, 1'b0);
      idle_on = 1'b0;
      run_phase(ORIENT_0,   10'd33,  10'd511, 1'b1, 120, 1, 1'b0, 1'b0);

      if (errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
